### hdl/bc_pkg.sv
// Shared types and constants for the barometer compensation block.
`default_nettype none
package bc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_TEMP_CALIB  = 2'd0;
  localparam logic [1:0] REG_PRESS_LOW   = 2'd1;
  localparam logic [1:0] REG_PRESS_MID   = 2'd2;
  localparam logic [1:0] REG_PRESS_HIGH  = 2'd3;

  localparam int unsigned RAW_W   = 24;
  localparam int unsigned ITEM_W  = 2 * RAW_W;
  localparam int unsigned CFG_W   = 48;
  localparam int unsigned PRESS_W = 22;

  // Unpacked calibration coefficients (signedness applied at use)
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [7:0]  t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [7:0]  p3;
    logic [7:0]  p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [7:0]  p7;
    logic [7:0]  p8;
    logic [15:0] p9;
    logic [7:0]  p10;
    logic [7:0]  p11;
  } bc_coef_t;

  // Front-end beat handed to the arithmetic pipeline
  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } bc_item_t;

endpackage
`default_nettype wire

### hdl/bc_fifo.sv
// Input queue between the stream slave port and the arithmetic pipeline.
`default_nettype none
module bc_fifo
  import bc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_valid,
  output logic          wr_ready,
  input  wire bc_item_t wr_data,
  output logic          rd_valid,
  input  wire logic     rd_pop,
  output bc_item_t      rd_data
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bc_item_t        mem_r [DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push, pop;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end
endmodule
`default_nettype wire

### hdl/bc_pipe.sv
// Compensation arithmetic pipeline with its output register.
`default_nettype none
module bc_pipe
  import bc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bc_coef_t      coef,
  input  wire logic          in_valid,
  input  wire bc_item_t      in_item,
  output logic               in_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic signed [15:0] out_temperature,
  output logic [PRESS_W-1:0] out_pressure,
  output logic               out_temp_clamped,
  output logic               out_press_clamped
);
  localparam int unsigned NSTG = 9;

  logic            adv;
  logic [NSTG-1:0] vld_r;
  logic            out_valid_r;

  // Stage 0
  logic signed [25:0] d0_r;
  logic [23:0]        up0_r;
  // Stage 1
  logic signed [42:0] m1_r;
  logic signed [51:0] dd1_r;
  logic [23:0]        up1_r;
  // Stage 2
  logic signed [63:0] num2_r;
  logic [23:0]        up2_r;
  // Stage 3
  logic signed [15:0] tout3_r, tout4_r, tout5_r, tout6_r, tout7_r, tout8_r;
  logic               tcl3_r, tcl4_r, tcl5_r, tcl6_r, tcl7_r, tcl8_r;
  logic signed [23:0] t3_r, t4_r;
  logic [23:0]        up3_r, up4_r, up5_r, up6_r, up7_r;
  // Stage 4
  logic signed [47:0] t2_4_r;
  logic signed [40:0] b4_r, b5_r, b6_r, b7_r;
  logic signed [33:0] r4_r;
  logic signed [40:0] q2p4_r;
  logic [47:0]        uu4_r;
  // Stage 5
  logic signed [55:0] cub5_r;
  logic signed [39:0] c5_r, c6_r, c7_r;
  logic signed [31:0] q3_5_r, q3_6_r;
  logic signed [35:0] q2_5_r, q2_6_r;
  logic signed [58:0] ar5_r;
  logic signed [56:0] a11_5_r;
  // Stage 6
  logic signed [40:0] d6_r, d7_r;
  logic signed [34:0] q4_6_r;
  logic signed [59:0] fh6_r;
  logic [47:0]        fl6_r;
  logic signed [57:0] gh6_r;
  logic [47:0]        gl6_r;
  // Stage 7
  logic signed [39:0] q7_r;
  logic signed [47:0] f7_r, g7_r;
  // Stage 8
  logic signed [49:0] e8_r;
  logic signed [63:0] s8_r;
  // Output
  logic signed [15:0] otemp_r;
  logic [PRESS_W-1:0] opress_r;
  logic               otcl_r, opcl_r;

  // Advance the whole pipe unless the output beat is stuck
  assign adv       = !out_valid_r || out_ready;
  assign in_pop    = adv;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], in_valid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  // Stage 0: temperature offset
  logic signed [25:0] d0_nxt;
  assign d0_nxt = $signed({2'b00, in_item.raw_temperature})
                - $signed({2'b00, coef.t1, 8'd0});

  // Stage 1: linear and square temperature products
  logic signed [42:0] m1_nxt;
  logic signed [51:0] dd1_nxt;
  assign m1_nxt  = d0_r * $signed({1'b0, coef.t2});
  assign dd1_nxt = d0_r * d0_r;

  // Stage 2: numerator of the temperature polynomial
  logic signed [59:0] ddt2;
  logic signed [63:0] num2_nxt;
  assign ddt2     = dd1_r * $signed(coef.t3);
  assign num2_nxt = $signed({{3{m1_r[42]}}, m1_r, 18'd0}) + $signed({{4{ddt2[59]}}, ddt2});

  // Stage 3: round and clamp output and internal temperature
  logic signed [63:0] trnd3, tq3;
  logic signed [15:0] tout3_nxt;
  logic               tcl3_nxt;
  logic signed [23:0] t3_nxt;
  assign trnd3 = (num2_r + 64'sd549755813888) >>> 40;
  assign tq3   = (num2_r + 64'sd2147483648) >>> 32;
  always_comb begin
    tout3_nxt = trnd3[15:0];
    tcl3_nxt  = 1'b0;
    if (trnd3 < -64'sd32768) begin
      tout3_nxt = -16'sd32768;
      tcl3_nxt  = 1'b1;
    end else if (trnd3 > 64'sd32767) begin
      tout3_nxt = 16'sd32767;
      tcl3_nxt  = 1'b1;
    end
    t3_nxt = tq3[23:0];
    if (tq3 < -64'sd8388608) begin
      t3_nxt = -24'sd8388608;
    end else if (tq3 > 64'sd8388607) begin
      t3_nxt = 24'sd8388607;
    end
  end

  // Stage 4: first products of the internal temperature, raw pressure square
  logic signed [16:0] p2m;
  logic signed [33:0] p10t;
  logic signed [47:0] t2_4_nxt;
  logic signed [40:0] b4_nxt, q2p4_nxt;
  logic signed [33:0] r4_nxt;
  logic [47:0]        uu4_nxt;
  assign p2m      = $signed({coef.p2[15], coef.p2}) - 17'sd16384;
  assign t2_4_nxt = t3_r * t3_r;
  assign b4_nxt   = $signed({1'b0, coef.p6}) * t3_r;
  assign p10t     = $signed(coef.p10) * t3_r;
  assign r4_nxt   = $signed({{2{coef.p9[15]}}, coef.p9, 16'd0}) + p10t;
  assign q2p4_nxt = p2m * t3_r;
  assign uu4_nxt  = up3_r * up3_r;

  // Stage 5: cube, square terms and raw pressure products
  logic signed [47:0] t2rs5;
  logic signed [55:0] cub5_nxt, pc5, pq35;
  logic signed [55:0] c5w, q35w;
  logic signed [40:0] q25w;
  logic signed [58:0] ar5_nxt;
  logic signed [56:0] a11_5_nxt;
  assign t2rs5     = (t2_4_r + 48'sd32768) >>> 16;
  assign cub5_nxt  = $signed(t2rs5[31:0]) * t4_r;
  assign pc5       = $signed(coef.p7) * t2_4_r;
  assign c5w       = (pc5 + 56'sd32768) >>> 16;
  assign pq35      = $signed(coef.p3) * t2_4_r;
  assign q35w      = (pq35 + 56'sd8388608) >>> 24;
  assign q25w      = (q2p4_r + 41'sd16) >>> 5;
  assign ar5_nxt   = $signed({1'b0, up4_r}) * r4_r;
  assign a11_5_nxt = $signed({1'b0, uu4_r}) * $signed(coef.p11);

  // Stage 6: cube terms and split high-order pressure products
  logic signed [63:0] pd6, pq46, d6w, q46w;
  logic signed [59:0] fh6_nxt;
  logic signed [57:0] gh6_nxt;
  logic [47:0]        fl6_nxt, gl6_nxt;
  assign pd6     = $signed(coef.p8) * cub5_r;
  assign d6w     = (pd6 + 64'sd4194304) >>> 23;
  assign pq46    = $signed(coef.p4) * cub5_r;
  assign q46w    = (pq46 + 64'sd268435456) >>> 29;
  assign fh6_nxt = $signed(ar5_r[58:24]) * $signed({1'b0, up5_r});
  assign fl6_nxt = ar5_r[23:0] * up5_r;
  assign gh6_nxt = $signed(a11_5_r[56:24]) * $signed({1'b0, up5_r});
  assign gl6_nxt = a11_5_r[23:0] * up5_r;

  // Stage 7: pressure sensitivity and rounded cubic pressure terms
  logic signed [16:0] p1m;
  logic signed [39:0] q7_nxt;
  logic signed [87:0] fs7, gs7;
  assign p1m    = $signed({coef.p1[15], coef.p1}) - 17'sd16384;
  assign q7_nxt = $signed({{3{p1m[16]}}, p1m, 20'd0}) + q2_6_r + q3_6_r + q4_6_r;
  assign fs7    = ($signed({{4{fh6_r[59]}}, fh6_r, 24'd0}) + $signed({40'd0, fl6_r})
                + 88'sd549755813888) >>> 40;
  assign gs7    = ($signed({{6{gh6_r[57]}}, gh6_r, 24'd0}) + $signed({40'd0, gl6_r})
                + 88'sd1099511627776) >>> 41;

  // Stage 8: pressure times sensitivity, sum of the other terms
  logic signed [65:0] pe8, e8w;
  logic signed [63:0] s8_nxt;
  assign pe8    = $signed({1'b0, up7_r}) * q7_r;
  assign e8w    = (pe8 + 66'sd32768) >>> 16;
  assign s8_nxt = $signed({20'd0, coef.p5, 28'd0} >> 1)
                + $signed({{21{b7_r[40]}}, b7_r, 2'd0})
                + c7_r + d7_r + f7_r + g7_r;

  // Output: final sum, rounding and saturation
  logic signed [63:0] sum9, pr9;
  logic [PRESS_W-1:0] opress_nxt;
  logic               opcl_nxt;
  assign sum9 = s8_r + e8_r;
  assign pr9  = (sum9 + 64'sd524288) >>> 20;
  always_comb begin
    opress_nxt = pr9[PRESS_W-1:0];
    opcl_nxt   = 1'b0;
    if (pr9 < 64'sd0) begin
      opress_nxt = '0;
      opcl_nxt   = 1'b1;
    end else if (pr9 > 64'sd4194303) begin
      opress_nxt = '1;
      opcl_nxt   = 1'b1;
    end
  end

  // Hold all payload while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      d0_r    <= d0_nxt;
      up0_r   <= in_item.raw_pressure;
      m1_r    <= m1_nxt;
      dd1_r   <= dd1_nxt;
      up1_r   <= up0_r;
      num2_r  <= num2_nxt;
      up2_r   <= up1_r;
      tout3_r <= tout3_nxt;
      tcl3_r  <= tcl3_nxt;
      t3_r    <= t3_nxt;
      up3_r   <= up2_r;
      t2_4_r  <= t2_4_nxt;
      b4_r    <= b4_nxt;
      r4_r    <= r4_nxt;
      q2p4_r  <= q2p4_nxt;
      uu4_r   <= uu4_nxt;
      t4_r    <= t3_r;
      up4_r   <= up3_r;
      tout4_r <= tout3_r;
      tcl4_r  <= tcl3_r;
      cub5_r  <= cub5_nxt;
      c5_r    <= c5w[39:0];
      q3_5_r  <= q35w[31:0];
      q2_5_r  <= q25w[35:0];
      ar5_r   <= ar5_nxt;
      a11_5_r <= a11_5_nxt;
      b5_r    <= b4_r;
      up5_r   <= up4_r;
      tout5_r <= tout4_r;
      tcl5_r  <= tcl4_r;
      d6_r    <= d6w[40:0];
      q4_6_r  <= q46w[34:0];
      fh6_r   <= fh6_nxt;
      fl6_r   <= fl6_nxt;
      gh6_r   <= gh6_nxt;
      gl6_r   <= gl6_nxt;
      q2_6_r  <= q2_5_r;
      q3_6_r  <= q3_5_r;
      c6_r    <= c5_r;
      b6_r    <= b5_r;
      up6_r   <= up5_r;
      tout6_r <= tout5_r;
      tcl6_r  <= tcl5_r;
      q7_r    <= q7_nxt;
      f7_r    <= fs7[47:0];
      g7_r    <= gs7[47:0];
      d7_r    <= d6_r;
      c7_r    <= c6_r;
      b7_r    <= b6_r;
      up7_r   <= up6_r;
      tout7_r <= tout6_r;
      tcl7_r  <= tcl6_r;
      e8_r    <= e8w[49:0];
      s8_r    <= s8_nxt;
      tout8_r <= tout7_r;
      tcl8_r  <= tcl7_r;
      otemp_r  <= tout8_r;
      otcl_r   <= tcl8_r;
      opress_r <= opress_nxt;
      opcl_r   <= opcl_nxt;
    end
  end

  assign out_temperature   = otemp_r;
  assign out_pressure      = opress_r;
  assign out_temp_clamped  = otcl_r;
  assign out_press_clamped = opcl_r;
endmodule
`default_nettype wire

### hdl/barometer_compensation.sv
// Top level: calibration registers, input queue and compensation pipeline.
//
// Usage: raw samples enter on the in_ stream (one beat per sample), the
// compensated temperature, pressure and saturation flags leave on the out_
// stream, one beat per sample, in order. Calibration words are written on
// the cfg_ channel, always ready; the user must write them only while no
// sample is in flight, which the block leaves unchecked. Throughput: one
// sample per cycle while the receiver is ready; the arithmetic is a 9-stage
// pipeline with at most one multiply layer per stage, followed by an output
// register; a sample passes the queue, the stages, then that register.
// When the receiver stalls, the whole pipeline holds and the input queue
// keeps taking beats until it is full; in_tready then drops.
// Reset: clears the calibration registers to zero, empties the queue and
// invalidates every pipeline stage; no clearing pass is needed.
`default_nettype none
module barometer_compensation
  import bc_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [ITEM_W-1:0] in_tdata,  // raw_temperature[23:0], raw_pressure[47:24]
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [39:0]            out_tdata, // temperature[15:0], pressure[37:16],
                                            // temp_clamped[38], press_clamped[39]
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);
  logic [39:0]        temp_calib_r;
  logic [47:0]        press_low_r;
  logic [47:0]        press_mid_r;
  logic [31:0]        press_high_r;
  bc_coef_t           coef;
  bc_item_t           q_item;
  logic               q_valid, q_pop;
  logic signed [15:0] temperature;
  logic [PRESS_W-1:0] pressure;
  logic               temp_clamped, press_clamped;

  assign cfg_ready = 1'b1;

  // Latch calibration words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_low_r  <= '0;
      press_mid_r  <= '0;
      press_high_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TEMP_CALIB: temp_calib_r <= cfg_data[39:0];
        REG_PRESS_LOW:  press_low_r  <= cfg_data;
        REG_PRESS_MID:  press_mid_r  <= cfg_data;
        REG_PRESS_HIGH: press_high_r <= cfg_data[31:0];
        default:        ;
      endcase
    end
  end

  // Split calibration words into coefficients
  assign coef.t1  = temp_calib_r[15:0];
  assign coef.t2  = temp_calib_r[31:16];
  assign coef.t3  = temp_calib_r[39:32];
  assign coef.p1  = press_low_r[15:0];
  assign coef.p2  = press_low_r[31:16];
  assign coef.p3  = press_low_r[39:32];
  assign coef.p4  = press_low_r[47:40];
  assign coef.p5  = press_mid_r[15:0];
  assign coef.p6  = press_mid_r[31:16];
  assign coef.p7  = press_mid_r[39:32];
  assign coef.p8  = press_mid_r[47:40];
  assign coef.p9  = press_high_r[15:0];
  assign coef.p10 = press_high_r[23:16];
  assign coef.p11 = press_high_r[31:24];

  bc_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_data  (bc_item_t'({in_tdata[47:24], in_tdata[23:0]})),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_item)
  );

  bc_pipe u_pipe (
    .clk               (clk),
    .rst_n             (rst_n),
    .coef              (coef),
    .in_valid          (q_valid),
    .in_item           (q_item),
    .in_pop            (q_pop),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_temperature   (temperature),
    .out_pressure      (pressure),
    .out_temp_clamped  (temp_clamped),
    .out_press_clamped (press_clamped)
  );

  assign out_tdata = {press_clamped, temp_clamped, pressure, temperature};
endmodule
`default_nettype wire
